### src/firmware_update_receiver_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the firmware update receiver
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef FIRMWARE_UPDATE_RECEIVER_ASSERT_SVH
`define FIRMWARE_UPDATE_RECEIVER_ASSERT_SVH

// Same-cycle implication
`define FUR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("firmware update receiver: same-cycle check failed");

// Next-cycle implication
`define FUR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("firmware update receiver: next-cycle check failed");

`endif

### src/fur_pkg.sv
// ---------------------------------------------------------------------------
// fur_pkg
// Types and constants shared by the firmware update receiver modules.
// ---------------------------------------------------------------------------
package fur_pkg;

    localparam int SIZE_BITS  = 24;
    localparam int LANES      = 8;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int LANE_SUM_W = 8 + LANE_IDX_W;
    localparam int LEN_W      = 4;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_START  = 3'd1,
        ST_DATA   = 3'd2,
        ST_COMMIT = 3'd3,
        ST_ABORT  = 3'd4,
        ST_REJECT = 3'd5
    } status_t;

    // packet kind in ext_id[5:4]
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_TAIL   = 2'd3;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_TYPE     = 2'd0;
    localparam logic [1:0] REG_RUNNING_VERSION = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef logic [LANES-1:0][7:0] lane_bytes_t;

    typedef struct packed {
        logic        operation;
        logic [28:0] ext_id;
        logic [63:0] payload;
        logic [3:0]  length;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [23:0] flash_offset;
        logic [3:0]  write_length;
        logic [63:0] write_data;
        logic [31:0] image_version;
        logic [23:0] image_size;
        logic [15:0] image_checksum;
        logic        timeout_flag;
    } out_t;

endpackage

### src/fur_lane.sv
// ---------------------------------------------------------------------------
// fur_lane
// One payload byte lane: passes its byte when it lies within the frame length.
// ---------------------------------------------------------------------------
module fur_lane
    import fur_pkg::*;
(
    input  logic [LANE_IDX_W-1:0] lane_idx,
    input  logic [LEN_W-1:0]      length,
    input  logic [7:0]            byte_in,
    output logic [7:0]            byte_out
);

    logic in_range;

    assign in_range = (LEN_W'(lane_idx) < length);
    assign byte_out = in_range ? byte_in : 8'h00;

endmodule

### src/fur_merge.sv
// ---------------------------------------------------------------------------
// fur_merge
// Combines the byte lanes into the write word and their byte sum.
// ---------------------------------------------------------------------------
module fur_merge
    import fur_pkg::*;
(
    input  lane_bytes_t            lane_bytes,
    output logic [LANE_SUM_W-1:0]  lane_sum,
    output logic [LANES*8-1:0]     lane_word
);

    always_comb begin
        lane_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            lane_sum = lane_sum + LANE_SUM_W'(lane_bytes[k]);
        end
    end

    assign lane_word = lane_bytes;

endmodule

### src/firmware_update_receiver.sv
// ---------------------------------------------------------------------------
// firmware_update_receiver
// Firmware update session tracking, byte lanes and result register.
// ---------------------------------------------------------------------------
// Every input transaction (frame or timer tick) yields exactly one result
// transaction. Each item's result is computed combinationally and registered,
// and a new one is taken every cycle while the result register is empty or
// being drained at the same edge, so the sustained rate is one item per clock;
// m_valid is set in the cycle after acceptance. The eight payload bytes are masked by length in
// parallel lanes and summed in a merge stage. Configuration writes are always
// accepted (cfg_ready is tied high) and must only be issued while idle.
// ---------------------------------------------------------------------------
`include "firmware_update_receiver_assert.svh"

module firmware_update_receiver
    import fur_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [11:0] device_type_reg;
    logic [31:0] running_version_reg;
    logic [31:0] timeout_ticks_reg;

    // session state
    logic                 session_open_reg,   session_open_next;
    logic [3:0]           expected_stamp_reg, expected_stamp_next;
    logic [SIZE_BITS-1:0] bytes_received_reg, bytes_received_next;
    logic [15:0]          byte_sum_reg,       byte_sum_next;
    logic [SIZE_BITS-1:0] announced_size_reg, announced_size_next;
    logic                 aborted_flag_reg,   aborted_flag_next;
    logic [31:0]          idle_ticks_reg,     idle_ticks_next;

    logic m_valid_reg;
    out_t m_data_reg, m_data_next;

    logic s_fire;
    logic cfg_fire;

    lane_bytes_t           raw_bytes;
    lane_bytes_t           lane_bytes;
    logic [LANE_SUM_W-1:0] lane_sum;
    logic [63:0]           lane_word;

    logic [31:0] frame_version;
    logic [11:0] frame_type;
    logic [23:0] frame_size;
    logic [15:0] frame_sum;
    logic        type_ok;
    logic        version_ok;
    logic        timed_out;
    logic        sess_live;
    logic [SIZE_BITS-1:0] br_live;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // byte lanes
    assign raw_bytes = s_data.payload;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        fur_lane u_lane (
            .lane_idx (LANE_IDX_W'(k)),
            .length   (s_data.length),
            .byte_in  (raw_bytes[k]),
            .byte_out (lane_bytes[k])
        );
    end

    fur_merge u_merge (
        .lane_bytes (lane_bytes),
        .lane_sum   (lane_sum),
        .lane_word  (lane_word)
    );

    // header and tail fields, taken from the payload whatever the length
    assign frame_version = {s_data.ext_id[3:0], raw_bytes[0], raw_bytes[1],
                            raw_bytes[2], raw_bytes[3][7:4]};
    assign frame_type    = {raw_bytes[3][3:0], raw_bytes[4]};
    assign frame_size    = {raw_bytes[5], raw_bytes[6], raw_bytes[7]};
    assign frame_sum     = {raw_bytes[5], raw_bytes[6]};
    assign type_ok       = (frame_type == device_type_reg);
    assign version_ok    = (frame_version > running_version_reg);

    assign timed_out = session_open_reg && (idle_ticks_reg > timeout_ticks_reg);
    assign sess_live = session_open_reg && !timed_out;
    assign br_live   = timed_out ? '0 : bytes_received_reg;

    always_comb begin
        session_open_next   = session_open_reg;
        expected_stamp_next = expected_stamp_reg;
        bytes_received_next = bytes_received_reg;
        byte_sum_next       = byte_sum_reg;
        announced_size_next = announced_size_reg;
        aborted_flag_next   = aborted_flag_reg;
        idle_ticks_next     = idle_ticks_reg;
        m_data_next         = '0;
        m_data_next.status  = ST_NONE;

        if (s_data.operation == OP_TICK) begin
            if (idle_ticks_reg != '1) begin
                idle_ticks_next = idle_ticks_reg + 32'd1;
            end
        end else if (s_data.length > LEN_W'(LANES)) begin
            m_data_next.status = ST_REJECT;
        end else begin
            session_open_next   = sess_live;
            bytes_received_next = br_live;
            if (timed_out) begin
                aborted_flag_next = 1'b1;
            end
            if (!s_data.ext_id[6]) begin
                aborted_flag_next  = 1'b1;
                session_open_next  = 1'b0;
                m_data_next.status = ST_ABORT;
            end else begin
                aborted_flag_next = 1'b0;
                idle_ticks_next   = '0;
                case (s_data.ext_id[5:4])
                    KIND_HEADER: begin
                        announced_size_next = SIZE_BITS'(frame_size);
                        if (type_ok && version_ok) begin
                            session_open_next   = 1'b1;
                            bytes_received_next = '0;
                            byte_sum_next       = '0;
                            expected_stamp_next = '0;
                            m_data_next.status  = ST_START;
                        end else begin
                            m_data_next.status = ST_REJECT;
                        end
                    end
                    KIND_DATA: begin
                        if (!sess_live) begin
                            m_data_next.status = ST_REJECT;
                            idle_ticks_next    = idle_ticks_reg;
                        end else if (s_data.ext_id[3:0] == expected_stamp_reg) begin
                            expected_stamp_next = expected_stamp_reg + 4'd1;
                            byte_sum_next = byte_sum_reg + 16'(lane_sum);
                            bytes_received_next = br_live + SIZE_BITS'(s_data.length);
                            m_data_next.status       = ST_DATA;
                            m_data_next.flash_offset = 24'(br_live);
                            m_data_next.write_length = s_data.length;
                            m_data_next.write_data   = lane_word;
                        end
                    end
                    KIND_TAIL: begin
                        if (!sess_live) begin
                            m_data_next.status = ST_REJECT;
                            idle_ticks_next    = idle_ticks_reg;
                        end else if (type_ok && version_ok &&
                                     br_live == announced_size_reg &&
                                     frame_sum == byte_sum_reg) begin
                            m_data_next.status         = ST_COMMIT;
                            m_data_next.image_version  = frame_version;
                            m_data_next.image_size     = 24'(announced_size_reg);
                            m_data_next.image_checksum = frame_sum;
                        end else begin
                            aborted_flag_next  = 1'b1;
                            session_open_next  = 1'b0;
                            m_data_next.status = ST_ABORT;
                        end
                    end
                    default: begin
                        // kind zero
                        m_data_next.status = ST_REJECT;
                        idle_ticks_next    = idle_ticks_reg;
                    end
                endcase
            end
            if (timed_out && (m_data_next.status == ST_NONE ||
                              m_data_next.status == ST_REJECT)) begin
                m_data_next.status = ST_ABORT;
            end
        end
        m_data_next.timeout_flag = aborted_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_type_reg     <= '0;
            running_version_reg <= '0;
            timeout_ticks_reg   <= TIMEOUT_RESET;
            session_open_reg    <= 1'b0;
            expected_stamp_reg  <= '0;
            bytes_received_reg  <= '0;
            byte_sum_reg        <= '0;
            announced_size_reg  <= '0;
            aborted_flag_reg    <= 1'b0;
            idle_ticks_reg      <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (cfg_index)
                    REG_DEVICE_TYPE:     device_type_reg     <= cfg_data[11:0];
                    REG_RUNNING_VERSION: running_version_reg <= cfg_data;
                    REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                session_open_reg   <= session_open_next;
                expected_stamp_reg <= expected_stamp_next;
                bytes_received_reg <= bytes_received_next;
                byte_sum_reg       <= byte_sum_next;
                announced_size_reg <= announced_size_next;
                aborted_flag_reg   <= aborted_flag_next;
                idle_ticks_reg     <= idle_ticks_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    `FUR_ASSERT_NEXT(a_commit_keeps_session, s_fire && m_data_next.status == ST_COMMIT, session_open_reg)
    `FUR_ASSERT_NEXT(a_start_clears_counts, s_fire && m_data_next.status == ST_START, bytes_received_reg == '0 && byte_sum_reg == '0 && expected_stamp_reg == '0)
    `FUR_ASSERT_NOW(a_write_fields_only_on_data, m_valid_reg && m_data_reg.status != ST_DATA, m_data_reg.write_length == '0 && m_data_reg.write_data == '0)
    `FUR_ASSERT_NOW(a_flag_follows_state, m_valid_reg && !s_fire, m_data_reg.timeout_flag == aborted_flag_reg)

endmodule

### sim/tb_firmware_update_receiver.sv
// ---------------------------------------------------------------------------
// tb_firmware_update_receiver
// Self-checking bench for the firmware update receiver. A behavioural model
// of the session tracker predicts one result per accepted transaction; results
// are compared field by field in order. Directed cases cover the corners, then
// random update sessions run under several register settings with random
// back-pressure on the result channel and random gaps on the input.
// ---------------------------------------------------------------------------
module tb_firmware_update_receiver
    import fur_pkg::*;
();

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_ITEMS = 290;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    firmware_update_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model registers
    logic [11:0] cfg_dev_type = 12'd0;
    logic [31:0] cfg_run_ver  = 32'd0;
    logic [31:0] cfg_timeout  = TIMEOUT_RESET;

    // model session state
    logic        sess_open      = 1'b0;
    logic [3:0]  next_stamp     = 4'd0;
    logic [23:0] byte_count     = 24'd0;
    logic [15:0] running_sum    = 16'd0;
    logic [23:0] size_announced = 24'd0;
    logic        abort_seen     = 1'b0;
    logic [31:0] idle_count     = 32'd0;

    out_t awaited_results [$];
    out_t oldest;
    int   mismatches  = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    bit   gaps_on     = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_firmware_update_receiver: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= 18);
    end

    // Works out the result of one transaction and advances the model state
    function automatic out_t predict_receiver_output(input in_t it);
        out_t        r;
        logic [31:0] ver;
        logic [11:0] typ;
        logic [15:0] tail_sum;
        logic [1:0]  kind;
        logic        lapsed;
        logic        touch;
        int          k;
        r        = '0;
        r.status = ST_NONE;
        lapsed   = 1'b0;
        ver      = {it.ext_id[3:0], it.payload[7:0], it.payload[15:8], it.payload[23:16],
                    it.payload[31:28]};
        typ      = {it.payload[27:24], it.payload[39:32]};
        tail_sum = {it.payload[47:40], it.payload[55:48]};
        if (it.operation == OP_TICK) begin
            if (idle_count != '1) idle_count = idle_count + 1;
        end else if (it.length > 8) begin
            r.status = ST_REJECT;
        end else begin
            if (sess_open && idle_count > cfg_timeout) begin
                lapsed     = 1'b1;
                abort_seen = 1'b1;
                sess_open  = 1'b0;
                byte_count = '0;
            end
            if (!it.ext_id[6]) begin
                abort_seen = 1'b1;
                sess_open  = 1'b0;
                r.status   = ST_ABORT;
            end else begin
                kind       = it.ext_id[5:4];
                touch      = 1'b1;
                abort_seen = 1'b0;
                if (kind == KIND_HEADER) begin
                    size_announced = {it.payload[47:40], it.payload[55:48], it.payload[63:56]};
                    if (typ == cfg_dev_type && ver > cfg_run_ver) begin
                        sess_open   = 1'b1;
                        byte_count  = '0;
                        running_sum = '0;
                        next_stamp  = '0;
                        r.status    = ST_START;
                    end else begin
                        r.status = ST_REJECT;
                    end
                end else if (kind == KIND_DATA && sess_open) begin
                    // a stale or future stamp is dropped silently
                    if (it.ext_id[3:0] == next_stamp) begin
                        next_stamp = next_stamp + 4'd1;
                        for (k = 0; k < it.length; k++) begin
                            running_sum = running_sum + 16'(it.payload[8*k +: 8]);
                            r.write_data[8*k +: 8] = it.payload[8*k +: 8];
                        end
                        r.flash_offset = byte_count;
                        r.write_length = it.length;
                        byte_count     = byte_count + 24'(it.length);
                        r.status       = ST_DATA;
                    end
                end else if (kind == KIND_TAIL && sess_open) begin
                    if (typ == cfg_dev_type && ver > cfg_run_ver &&
                        byte_count == size_announced && tail_sum == running_sum) begin
                        r.image_version  = ver;
                        r.image_size     = size_announced;
                        r.image_checksum = tail_sum;
                        r.status         = ST_COMMIT;
                    end else begin
                        abort_seen = 1'b1;
                        sess_open  = 1'b0;
                        r.status   = ST_ABORT;
                    end
                end else begin
                    r.status = ST_REJECT;
                    touch    = 1'b0;
                end
                if (touch) idle_count = '0;
            end
            if (lapsed && (r.status == ST_NONE || r.status == ST_REJECT)) r.status = ST_ABORT;
        end
        r.timeout_flag = abort_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing outstanding");
                mismatches++;
            end else begin
                oldest = awaited_results.pop_front();
                check_field("status", oldest.status, m_data.status);
                check_field("flash_offset", oldest.flash_offset, m_data.flash_offset);
                check_field("write_length", oldest.write_length, m_data.write_length);
                check_field("write_data", oldest.write_data, m_data.write_data);
                check_field("image_version", oldest.image_version, m_data.image_version);
                check_field("image_size", oldest.image_size, m_data.image_size);
                check_field("image_checksum", oldest.image_checksum, m_data.image_checksum);
                check_field("timeout_flag", oldest.timeout_flag, m_data.timeout_flag);
            end
        end
    end

    // Called at a clock edge; leaves valid high after acceptance so the next
    // transaction can follow back to back.
    task automatic send_item(input in_t it);
        if (gaps_on && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 40);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(predict_receiver_output(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DEVICE_TYPE:     cfg_dev_type = value[11:0];
            REG_RUNNING_VERSION: cfg_run_ver  = value;
            REG_TIMEOUT_TICKS:   cfg_timeout  = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic in_t raw_frame(input logic [28:0] id, input logic [63:0] pl,
                                      input logic [3:0] len);
        in_t f;
        f.operation = OP_FRAME;
        f.ext_id    = id;
        f.payload   = pl;
        f.length    = len;
        return f;
    endfunction

    function automatic in_t tick_item();
        in_t f;
        f           = raw_frame(29'($urandom()), {$urandom(), $urandom()}, 4'($urandom()));
        f.operation = OP_TICK;
        return f;
    endfunction

    function automatic in_t noise_item();
        in_t f;
        f           = raw_frame(29'($urandom()), {$urandom(), $urandom()}, 4'($urandom()));
        f.operation = 1'($urandom());
        return f;
    endfunction

    // header or tail; fld fills bytes 5..7 (size, or sum plus a spare byte)
    function automatic in_t image_frame(input logic [1:0] kind, input logic [31:0] ver,
                                        input logic [11:0] typ, input logic [23:0] fld);
        return raw_frame({22'($urandom()), 1'b1, kind, ver[31:28]},
                         {fld[7:0], fld[15:8], fld[23:16], typ[7:0], ver[3:0], typ[11:8],
                          ver[11:4], ver[19:12], ver[27:20]},
                         4'($urandom_range(0, 8)));
    endfunction

    function automatic in_t data_frame(input logic [3:0] stamp, input logic [3:0] len,
                                       input logic [63:0] pl);
        return raw_frame({22'($urandom()), 1'b1, KIND_DATA, stamp}, pl, len);
    endfunction

    function automatic logic [31:0] newer_version();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0 && cfg_run_ver != '1) return cfg_run_ver + 32'd1;
        v = $urandom();
        if (v <= cfg_run_ver) v = '1;
        return v;
    endfunction

    function automatic in_t good_tail();
        return image_frame(KIND_TAIL, newer_version(), cfg_dev_type,
                           {running_sum, 8'($urandom())});
    endfunction

    function automatic in_t good_header(input logic [23:0] size);
        return image_frame(KIND_HEADER, newer_version(), cfg_dev_type, size);
    endfunction

    task automatic test_directed();
        send_item(tick_item());
        send_item(raw_frame(29'h50, '1, 4'd9));
        send_item(raw_frame(29'h1FFFFFFF, '1, 4'd15));
        send_item(raw_frame(29'h0, '0, 4'd0));                  // mode bit clear
        send_item(raw_frame(29'h40, {$urandom(), $urandom()}, 4'd8));
        send_item(data_frame(4'd0, 4'd8, '1));                  // no session yet
        send_item(image_frame(KIND_TAIL, 32'd5, 12'd0, 24'd0));
        send_item(image_frame(KIND_HEADER, 32'd1, 12'hFFF, 24'd9));
        send_item(image_frame(KIND_HEADER, 32'd0, 12'd0, 24'd9)); // version not newer
        send_item(image_frame(KIND_HEADER, '1, 12'd0, 24'd9));
        send_item(data_frame(4'd0, 4'd8, '1));
        send_item(data_frame(4'd7, 4'd4, {$urandom(), $urandom()}));
        send_item(image_frame(KIND_HEADER, 32'd3, 12'h123, 24'd9)); // session survives
        send_item(data_frame(4'd1, 4'd1, {$urandom(), $urandom()}));
        send_item(data_frame(4'd2, 4'd0, '1));
        send_item(good_tail());
        send_item(data_frame(4'd3, 4'd3, {$urandom(), $urandom()})); // still open after commit
        send_item(good_tail());                                    // size now off
        send_item(image_frame(KIND_HEADER, 32'd1, 12'd0, 24'd0));
        send_item(good_tail());
        send_item(raw_frame(29'h1FFFFFBF, '1, 4'd8));
        send_item(raw_frame(29'h1FFFFFFF, '1, 4'd8));
        wait_drained();
        write_reg(REG_RUNNING_VERSION, '1);
        send_item(image_frame(KIND_HEADER, '1, 12'd0, 24'd0));
    endtask

    task automatic test_idle_timeout();
        wait_drained();
        write_reg(REG_TIMEOUT_TICKS, 32'd0);
        write_reg(REG_DEVICE_TYPE, 32'hABCDE5A5);
        write_reg(REG_RUNNING_VERSION, 32'h0000_1000);
        send_item(good_header(24'd0));
        send_item(tick_item());
        send_item(data_frame(4'd0, 4'd4, {$urandom(), $urandom()}));  // expired session
        send_item(good_header(24'd0));
        send_item(tick_item());
        send_item(good_header(24'd4));                                // expired, reopens
        send_item(tick_item());
        send_item(raw_frame(29'h30, '0, 4'd2));
        send_item(good_header(24'd0));
        send_item(tick_item());
        send_item(raw_frame(29'h1FFFFF4F, '0, 4'd2));                // kind zero
        wait_drained();
        write_reg(REG_TIMEOUT_TICKS, 32'd3);
        send_item(good_header(24'd4));
        repeat (3) send_item(tick_item());
        send_item(data_frame(4'd0, 4'd4, {$urandom(), $urandom()}));
        repeat (4) send_item(tick_item());
        send_item(good_tail());
        wait_drained();
        write_reg(REG_TIMEOUT_TICKS, '1);
        send_item(good_header(24'd0));
        repeat (5) send_item(tick_item());
        send_item(good_tail());
    endtask

    task automatic maybe_noise();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) repeat ($urandom_range(1, 3)) send_item(tick_item());
        else if (roll < 11) send_item(noise_item());
    endtask

    // One update: header, data in order with the odd bad stamp, then a tail
    task automatic run_session();
        logic [3:0] lens [$];
        int         n;
        int         total;
        int         k;
        int         b;
        in_t        tl;
        n     = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 8);
        total = 0;
        for (k = 0; k < n; k++) begin
            lens.push_back(4'($urandom_range(0, 8)));
            total += lens[k];
        end
        maybe_noise();
        send_item(good_header(24'(total)));
        for (k = 0; k < n; k++) begin
            maybe_noise();
            if ($urandom_range(0, 9) == 0)
                send_item(data_frame(next_stamp + 4'($urandom_range(1, 15)),
                                     4'($urandom_range(0, 8)), {$urandom(), $urandom()}));
            send_item(data_frame(next_stamp, lens[k], {$urandom(), $urandom()}));
        end
        maybe_noise();
        tl = good_tail();
        case ($urandom_range(0, 9))
            0: begin
                b = $urandom_range(40, 55);
                tl.payload[b] = ~tl.payload[b];
            end
            1: begin
                b = $urandom_range(32, 39);
                tl.payload[b] = ~tl.payload[b];
            end
            2: tl = image_frame(KIND_TAIL, cfg_run_ver, cfg_dev_type, {running_sum, 8'd0});
            3: send_item(data_frame(next_stamp, 4'($urandom_range(1, 8)), '1));
            default: ;
        endcase
        send_item(tl);
        if ($urandom_range(0, 9) == 0) send_item(good_tail());
    endtask

    task automatic test_random_sessions();
        int phase;
        int target;
        logic [31:0] tmo;
        for (phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(REG_DEVICE_TYPE, 32'h0);
                    write_reg(REG_RUNNING_VERSION, 32'h0);
                    write_reg(REG_TIMEOUT_TICKS, '1);
                end
                1: begin
                    write_reg(REG_DEVICE_TYPE, 32'hFFFF_FFFF);
                    write_reg(REG_RUNNING_VERSION, 32'hFFFF_FFFE);
                    write_reg(REG_TIMEOUT_TICKS, 32'd0);
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: tmo = $urandom_range(2, 40);
                        1: tmo = TIMEOUT_RESET;
                        default: tmo = $urandom();
                    endcase
                    write_reg(REG_DEVICE_TYPE, $urandom());
                    write_reg(REG_RUNNING_VERSION, $urandom() >> $urandom_range(0, 31));
                    write_reg(REG_TIMEOUT_TICKS, tmo);
                end
            endcase
            gaps_on = (phase != 3);     // one long stretch at full rate
            target  = items_sent + PHASE_ITEMS;
            while (items_sent < target) run_session();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_idle_timeout();
        test_random_sessions();
        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_firmware_update_receiver: clean");
        end else begin
            $display("tb_firmware_update_receiver: errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/fur_pkg.sv
src/fur_lane.sv
src/fur_merge.sv
src/firmware_update_receiver.sv
sim/tb_firmware_update_receiver.sv
